FILE: design/vde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vde_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 48;
  localparam int FRAC_W   = 16;
  localparam int MUL_W    = ACC_W / 2;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int RAD_W    = 2 * ACC_W;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int CMP_W    = REM_W + 2;

  localparam int ROOT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = FRAC_W;
  localparam int CNT_W      = $clog2(ROOT_STEPS);

  localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] DOT_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] DOT_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] DIST_MAX = {1'b0, {(ACC_W-1){1'b1}}};

  typedef enum logic [1:0] {
    MODE_EUCLID    = 2'd0,
    MODE_MANHATTAN = 2'd1,
    MODE_COSINE    = 2'd2,
    MODE_NONE      = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELEM,
    ST_LAST,
    ST_NMUL,
    ST_ROOT,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_req_t;

endpackage

`default_nettype wire

FILE: design/vde_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module vde_mul import vde_pkg::*; (
  input  wire              clk_i,
  input  wire  [MUL_W-1:0] op_a_i,
  input  wire  [MUL_W-1:0] op_b_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: design/vde_iter.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared compare/subtract unit: one root bit (from two radicand bits) or one quotient bit per cycle.
module vde_iter import vde_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  iter_req_t   req_i,
  input  wire  [RAD_W-1:0]  radicand_i,
  input  wire  [ACC_W-1:0]  dividend_i,
  input  wire  [ROOT_W-1:0] divisor_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] result_o
);

  logic              busy_q, done_q, is_div_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W-1:0] den_q;

  logic [CMP_W-1:0]  rem_s, trial, diff;
  logic              ge;
  logic [CNT_W-1:0]  cnt_last;

  always_comb begin
    if (is_div_q) begin
      rem_s = CMP_W'({rem_q, 1'b0});
      trial = CMP_W'(den_q);
    end else begin
      rem_s = {rem_q, rad_q[RAD_W-1 -: 2]};
      trial = {1'b0, root_q, 2'b01};
    end
    ge       = (rem_s >= trial);
    diff     = rem_s - trial;
    cnt_last = is_div_q ? CNT_W'(DIV_STEPS - 1) : CNT_W'(ROOT_STEPS - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      is_div_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q   <= 1'b1;
        is_div_q <= req_i.is_div;
        cnt_q    <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == cnt_last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      root_q <= '0;
      rad_q  <= radicand_i;
      den_q  <= divisor_i;
      rem_q  <= req_i.is_div ? REM_W'(dividend_i) : '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? diff[REM_W-1:0] : rem_s[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o   = done_q;
  assign result_o = root_q;

endmodule

`default_nettype wire

FILE: design/vector_distance_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                       | Handshake
// ----------+---------------------------------------------+----------------------------
// input     | elem_a_i, elem_b_i, last_i                  | start_i high, busy_o low
// result    | distance_o, zero_norm_o, saturated_o        | result_valid_o, one cycle
// config    | cfg_data_i (mode)                           | cfg_we_i
//
// Each element pair keeps busy_o high while four products pass through the one 24x24
// multiplier, then the last accumulate; the next pair is taken once busy_o is low.
// A last pair then enters a dispatch state: Manhattan or unused mode finish there;
// Euclidean runs the square root; cosine finishes there on a zero norm, else it
// multiplies the norms, takes the root and divides unless the result caps at 1.0.
// Reset clears the mode and all sums. The result strobe cannot be stalled.
module vector_distance_engine import vde_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  wire  [SAMPLE_W-1:0] elem_a_i,
  input  wire  [SAMPLE_W-1:0] elem_b_i,
  input  wire                 last_i,
  input  wire                 cfg_we_i,
  input  wire  [1:0]          cfg_data_i,
  output logic                result_valid_o,
  output logic [ACC_W-1:0]    distance_o,
  output logic                zero_norm_o,
  output logic                saturated_o
);

  state_e state_q, state_d;
  mode_e  mode_q;
  logic [2:0] step_q, step_d;

  logic [SAMPLE_W-1:0] a_q, b_q;
  logic                last_q;

  logic [ACC_W-1:0] sq_q, abs_q, na_q, nb_q, dot_q;
  logic [ACC_W-1:0] sq_d, abs_d, na_d, nb_d, dot_d;
  logic             clip_q, clip_d;
  logic [RAD_W-1:0] prod_q, prod_d;

  logic             res_valid_q, res_valid_d;
  logic [ACC_W-1:0] dist_q, dist_d;
  logic             zn_q, zn_d, sat_q, sat_d;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  iter_req_t         iter_req;
  logic [RAD_W-1:0]  radicand;
  logic              iter_done;
  logic [ROOT_W-1:0] iter_res;

  logic [SAMPLE_W:0]   diff_ab, abs_ab;
  logic [SAMPLE_W-1:0] mag_a, mag_b;
  logic                ab_neg;
  logic [ACC_W-1:0]    dot_mag;
  logic                dot_neg;

  function automatic logic [ACC_W:0] add_u(input logic [ACC_W-1:0] acc,
                                           input logic [ACC_W-1:0] x);
    add_u = {1'b0, acc} + {1'b0, x};
  endfunction

  assign diff_ab = {a_q[SAMPLE_W-1], a_q} - {b_q[SAMPLE_W-1], b_q};
  assign abs_ab  = diff_ab[SAMPLE_W] ? -diff_ab : diff_ab;
  assign mag_a   = a_q[SAMPLE_W-1] ? -a_q : a_q;
  assign mag_b   = b_q[SAMPLE_W-1] ? -b_q : b_q;
  assign ab_neg  = a_q[SAMPLE_W-1] ^ b_q[SAMPLE_W-1];
  assign dot_neg = dot_q[ACC_W-1];
  assign dot_mag = dot_neg ? -dot_q : dot_q;

  vde_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  vde_iter u_iter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (iter_req),
    .radicand_i (radicand),
    .dividend_i (dot_mag),
    .divisor_i  (iter_res),
    .done_o     (iter_done),
    .result_o   (iter_res)
  );

  always_comb begin
    logic [ACC_W:0]   sum_u;
    logic [ACC_W:0]   sum_s;
    logic [ACC_W:0]   p_ext;
    logic [FRAC_W:0]  q;
    logic             finish;

    state_d     = state_q;
    step_d      = step_q;
    sq_d        = sq_q;
    abs_d       = abs_q;
    na_d        = na_q;
    nb_d        = nb_q;
    dot_d       = dot_q;
    clip_d      = clip_q;
    prod_d      = prod_q;
    mul_a       = '0;
    mul_b       = '0;
    iter_req    = '0;
    radicand    = prod_q;
    res_valid_d = 1'b0;
    dist_d      = dist_q;
    zn_d        = zn_q;
    sat_d       = sat_q;
    finish      = 1'b0;
    sum_u       = '0;
    sum_s       = '0;
    p_ext       = {1'b0, ACC_W'(prod)};
    q           = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_ELEM;
          step_d  = '0;
        end
      end

      ST_ELEM: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: begin
            mul_a = MUL_W'(abs_ab);
            mul_b = MUL_W'(abs_ab);
            sum_u = add_u(abs_q, ACC_W'(abs_ab));
            if (sum_u[ACC_W]) begin
              abs_d  = ACC_MAX;
              clip_d = 1'b1;
            end else begin
              abs_d = sum_u[ACC_W-1:0];
            end
          end
          3'd1: begin
            mul_a = MUL_W'(mag_a);
            mul_b = MUL_W'(mag_a);
            sum_u = add_u(sq_q, ACC_W'(prod));
            if (sum_u[ACC_W]) begin
              sq_d   = ACC_MAX;
              clip_d = 1'b1;
            end else begin
              sq_d = sum_u[ACC_W-1:0];
            end
          end
          3'd2: begin
            mul_a = MUL_W'(mag_b);
            mul_b = MUL_W'(mag_b);
            sum_u = add_u(na_q, ACC_W'(prod));
            if (sum_u[ACC_W]) begin
              na_d   = ACC_MAX;
              clip_d = 1'b1;
            end else begin
              na_d = sum_u[ACC_W-1:0];
            end
          end
          3'd3: begin
            mul_a = MUL_W'(mag_a);
            mul_b = MUL_W'(mag_b);
            sum_u = add_u(nb_q, ACC_W'(prod));
            if (sum_u[ACC_W]) begin
              nb_d   = ACC_MAX;
              clip_d = 1'b1;
            end else begin
              nb_d = sum_u[ACC_W-1:0];
            end
          end
          default: begin
            sum_s = {dot_q[ACC_W-1], dot_q} + (ab_neg ? -p_ext : p_ext);
            if (sum_s[ACC_W] != sum_s[ACC_W-1]) begin
              dot_d  = sum_s[ACC_W] ? DOT_MIN : DOT_MAX;
              clip_d = 1'b1;
            end else begin
              dot_d = sum_s[ACC_W-1:0];
            end
            state_d = last_q ? ST_LAST : ST_IDLE;
          end
        endcase
      end

      ST_LAST: begin
        case (mode_q)
          MODE_EUCLID: begin
            radicand        = RAD_W'(sq_q) << (2 * FRAC_W);
            iter_req.start  = 1'b1;
            iter_req.is_div = 1'b0;
            state_d         = ST_ROOT;
          end
          MODE_MANHATTAN: begin
            finish = 1'b1;
            zn_d   = 1'b0;
            if (abs_q > (DIST_MAX >> FRAC_W)) begin
              dist_d = DIST_MAX;
              sat_d  = 1'b1;
            end else begin
              dist_d = abs_q << FRAC_W;
              sat_d  = clip_q;
            end
          end
          MODE_COSINE: begin
            if (na_q == '0 || nb_q == '0) begin
              finish = 1'b1;
              dist_d = '0;
              zn_d   = 1'b1;
              sat_d  = clip_q;
            end else begin
              prod_d  = '0;
              step_d  = '0;
              state_d = ST_NMUL;
            end
          end
          default: begin
            finish = 1'b1;
            dist_d = '0;
            zn_d   = 1'b0;
            sat_d  = clip_q;
          end
        endcase
      end

      ST_NMUL: begin
        // 48x48 norm product from four 24x24 partial products
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: begin
            mul_a = na_q[MUL_W-1:0];
            mul_b = nb_q[MUL_W-1:0];
          end
          3'd1: begin
            mul_a  = na_q[MUL_W-1:0];
            mul_b  = nb_q[ACC_W-1:MUL_W];
            prod_d = prod_q + RAD_W'(prod);
          end
          3'd2: begin
            mul_a  = na_q[ACC_W-1:MUL_W];
            mul_b  = nb_q[MUL_W-1:0];
            prod_d = prod_q + (RAD_W'(prod) << MUL_W);
          end
          3'd3: begin
            mul_a  = na_q[ACC_W-1:MUL_W];
            mul_b  = nb_q[ACC_W-1:MUL_W];
            prod_d = prod_q + (RAD_W'(prod) << MUL_W);
          end
          default: begin
            prod_d          = prod_q + (RAD_W'(prod) << (2 * MUL_W));
            radicand        = prod_d;
            iter_req.start  = 1'b1;
            iter_req.is_div = 1'b0;
            state_d         = ST_ROOT;
          end
        endcase
      end

      ST_ROOT: begin
        if (iter_done) begin
          if (mode_q == MODE_EUCLID) begin
            finish = 1'b1;
            zn_d   = 1'b0;
            if (ACC_W'(iter_res) > DIST_MAX) begin
              dist_d = DIST_MAX;
              sat_d  = 1'b1;
            end else begin
              dist_d = ACC_W'(iter_res);
              sat_d  = clip_q;
            end
          end else if (dot_mag >= ACC_W'(iter_res)) begin
            // cap the magnitude at 1.0
            finish = 1'b1;
            q      = {1'b1, {FRAC_W{1'b0}}};
            dist_d = dot_neg ? -ACC_W'(q) : ACC_W'(q);
            zn_d   = 1'b0;
            sat_d  = clip_q;
          end else begin
            iter_req.start  = 1'b1;
            iter_req.is_div = 1'b1;
            state_d         = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (iter_done) begin
          finish = 1'b1;
          q      = {1'b0, iter_res[FRAC_W-1:0]};
          dist_d = dot_neg ? -ACC_W'(q) : ACC_W'(q);
          zn_d   = 1'b0;
          sat_d  = clip_q;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      res_valid_d = 1'b1;
      state_d     = ST_IDLE;
      sq_d        = '0;
      abs_d       = '0;
      na_d        = '0;
      nb_d        = '0;
      dot_d       = '0;
      clip_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      mode_q      <= MODE_EUCLID;
      sq_q        <= '0;
      abs_q       <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      dot_q       <= '0;
      clip_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sq_q        <= sq_d;
      abs_q       <= abs_d;
      na_q        <= na_d;
      nb_q        <= nb_d;
      dot_q       <= dot_d;
      clip_q      <= clip_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      a_q    <= elem_a_i;
      b_q    <= elem_b_i;
      last_q <= last_i;
    end
    prod_q <= prod_d;
    dist_q <= dist_d;
    zn_q   <= zn_d;
    sat_q  <= sat_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign distance_o     = dist_q;
  assign zero_norm_o    = zn_q;
  assign saturated_o    = sat_q;

endmodule

`default_nettype wire

FILE: sim/vector_distance_engine_tb.sv
`timescale 1ns / 1ps

module vector_distance_engine_tb;
  import vde_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          SETTLE_CYCLES  = 100;
  localparam int          MAX_GAP        = 18;
  localparam int          LONG_PAIRS     = 100;
  localparam int          PHASE_PAIRS    = 180;
  localparam int          REPORT_LIMIT   = 60;
  localparam longint      DOT_HI         = (longint'(1) <<< 47) - 1;
  localparam longint      DOT_LO         = -DOT_HI - 1;
  localparam logic [63:0] DIST_LIM       = (64'd1 << 47) - 1;

  typedef struct {
    logic [ACC_W-1:0] distance;
    logic             zero_norm;
    logic             saturated;
  } dist_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic [SAMPLE_W-1:0] elem_a_i = '0;
  logic [SAMPLE_W-1:0] elem_b_i = '0;
  logic                last_i = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_data_i = '0;
  logic                busy_o;
  logic                result_valid_o;
  logic [ACC_W-1:0]    distance_o;
  logic                zero_norm_o;
  logic                saturated_o;

  // predictor state
  mode_e                   mode_q = MODE_EUCLID;
  logic [ACC_W-1:0]        sq_sum = '0;
  logic [ACC_W-1:0]        abs_sum = '0;
  logic [ACC_W-1:0]        norm_a_sum = '0;
  logic [ACC_W-1:0]        norm_b_sum = '0;
  logic signed [ACC_W-1:0] dot_sum = '0;
  logic                    clip_seen = 1'b0;

  dist_result_t distance_q[$];
  int           errors = 0;
  int           quiet_cycles = 0;

  vector_distance_engine DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .elem_a_i       (elem_a_i),
    .elem_b_i       (elem_b_i),
    .last_i         (last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .distance_o     (distance_o),
    .zero_norm_o    (zero_norm_o),
    .saturated_o    (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] root_floor(input logic [127:0] x);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [63:0] root;
    rem  = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | 68'(x[2*i +: 2]);
      trial = {2'b00, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[62:0], 1'b1};
      end else begin
        root = {root[62:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [63:0] x);
    logic [63:0] s;
    s = 64'(acc) + x;
    if (s > 64'(ACC_MAX)) begin
      clip_seen = 1'b1;
      return ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  // Fold one pair into the sums; on a last pair queue the distance and clear.
  function automatic void accumulate_pair(input logic signed [SAMPLE_W-1:0] a,
                                          input logic signed [SAMPLE_W-1:0] b,
                                          input logic last);
    longint       sa, sb, diff, dsum;
    logic [63:0]  ad, den, mag, q, rem;
    logic [127:0] rad;
    logic         neg, oclip;
    dist_result_t res;
    sa   = a;
    sb   = b;
    diff = sa - sb;
    ad   = (diff < 0) ? 64'(-diff) : 64'(diff);
    sq_sum     = sat_add(sq_sum, ad * ad);
    abs_sum    = sat_add(abs_sum, ad);
    norm_a_sum = sat_add(norm_a_sum, 64'(sa * sa));
    norm_b_sum = sat_add(norm_b_sum, 64'(sb * sb));
    dsum = longint'(dot_sum) + sa * sb;
    if (dsum > DOT_HI) begin
      dsum = DOT_HI;
      clip_seen = 1'b1;
    end
    if (dsum < DOT_LO) begin
      dsum = DOT_LO;
      clip_seen = 1'b1;
    end
    dot_sum = dsum[ACC_W-1:0];
    if (!last) return;

    res.distance  = '0;
    res.zero_norm = 1'b0;
    oclip = 1'b0;
    case (mode_q)
      MODE_EUCLID: begin
        rad = 128'(sq_sum) << (2 * FRAC_W);
        q = root_floor(rad);
        if (q > DIST_LIM) begin
          q = DIST_LIM;
          oclip = 1'b1;
        end
        res.distance = q[ACC_W-1:0];
      end
      MODE_MANHATTAN: begin
        if (64'(abs_sum) > (DIST_LIM >> FRAC_W)) begin
          res.distance = DIST_LIM[ACC_W-1:0];
          oclip = 1'b1;
        end else begin
          res.distance = abs_sum << FRAC_W;
        end
      end
      MODE_COSINE: begin
        if (norm_a_sum == '0 || norm_b_sum == '0) begin
          res.zero_norm = 1'b1;
        end else begin
          neg = dot_sum < 0;
          rad = 128'(norm_a_sum) * 128'(norm_b_sum);
          den = root_floor(rad);
          mag = neg ? 64'(-longint'(dot_sum)) : 64'(longint'(dot_sum));
          q = '0;
          if (mag >= den) begin
            q = 64'd1 << FRAC_W;
          end else begin
            rem = mag;
            for (int i = 0; i < FRAC_W; i++) begin
              rem = rem << 1;
              q   = q << 1;
              if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
              end
            end
          end
          res.distance = neg ? (48'd0 - q[ACC_W-1:0]) : q[ACC_W-1:0];
        end
      end
      default: ;
    endcase
    res.saturated = clip_seen | oclip;
    distance_q.push_back(res);
    sq_sum     = '0;
    abs_sum    = '0;
    norm_a_sum = '0;
    norm_b_sum = '0;
    dot_sum    = '0;
    clip_seen  = 1'b0;
  endfunction

  // Start stays high after acceptance; lower it only when a gap follows.
  task automatic send_pair(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                           input logic last, input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    elem_a_i <= a;
    elem_b_i <= b;
    last_i   <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    accumulate_pair(a, b, last);
  endtask

  task automatic wait_until_idle();
    start_i <= 1'b0;
    while (distance_q.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input mode_e m);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 16)) - 16'd8;
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'hffff;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Mode left at reset must be Euclidean.
  task automatic test_reset_mode();
    send_pair(16'sd3, 16'sd0, 1'b0, pick_gap());
    send_pair(16'sd0, 16'sd4, 1'b1, pick_gap());
    send_pair(16'h8000, 16'h7fff, 1'b1, pick_gap());
    send_pair(16'sd0, 16'sd0, 1'b1, pick_gap());
    wait_until_idle();
  endtask

  task automatic test_manhattan();
    write_mode(MODE_MANHATTAN);
    send_pair(16'h7fff, 16'h8000, 1'b1, pick_gap());
    send_pair(-16'sd5, 16'sd7, 1'b0, pick_gap());
    send_pair(-16'sd1, -16'sd1, 1'b1, pick_gap());
    wait_until_idle();
  endtask

  task automatic test_cosine();
    write_mode(MODE_COSINE);
    // zero norm on either side
    send_pair(16'sd0, 16'sd9, 1'b1, pick_gap());
    send_pair(16'sd9, 16'sd0, 1'b1, pick_gap());
    // parallel vectors hit the 1.0 cap
    send_pair(16'sd3, 16'sd6, 1'b0, pick_gap());
    send_pair(-16'sd4, -16'sd8, 1'b1, pick_gap());
    // orthogonal vectors
    send_pair(16'sd2, 16'sd1, 1'b0, pick_gap());
    send_pair(-16'sd1, 16'sd2, 1'b1, pick_gap());
    send_pair(16'h8000, 16'h7fff, 1'b1, pick_gap());
    send_pair(16'sd7, -16'sd3, 1'b0, pick_gap());
    send_pair(16'sd5, 16'sd11, 1'b1, pick_gap());
    wait_until_idle();
  endtask

  task automatic test_unused_mode();
    write_mode(MODE_NONE);
    send_pair(16'sd100, -16'sd7, 1'b1, pick_gap());
    wait_until_idle();
  endtask

  // One longer vector of full-scale pairs sent back to back.
  task automatic test_full_scale();
    write_mode(MODE_MANHATTAN);
    for (int i = 0; i < LONG_PAIRS; i++) begin
      send_pair(16'h7fff, 16'h8000, i == LONG_PAIRS - 1, 0);
    end
    wait_until_idle();
  endtask

  task automatic test_random();
    mode_e phase_modes[8];
    int    sent;
    int    len;
    int    zero_side;
    int    pair_kind;
    bit    burst;
    logic [SAMPLE_W-1:0] a, b;
    phase_modes = '{MODE_COSINE, MODE_EUCLID, MODE_NONE, MODE_MANHATTAN,
                    MODE_COSINE, MODE_EUCLID, MODE_MANHATTAN, MODE_COSINE};
    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      sent = 0;
      while (sent < PHASE_PAIRS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
        zero_side = $urandom_range(0, 11);
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
          a = pick_sample();
          pair_kind = $urandom_range(0, 9);
          if (pair_kind == 0) b = a;
          else if (pair_kind == 1) b = -a;
          else b = pick_sample();
          if (zero_side == 0) a = '0;
          if (zero_side == 1) b = '0;
          send_pair(a, b, i == len - 1, burst ? 0 : pick_gap());
        end
        sent += len;
      end
      wait_until_idle();
    end
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    dist_result_t want;
    if (rst_ni && result_valid_o) begin
      if (distance_q.size() == 0) begin
        errors++;
        if (errors < REPORT_LIMIT)
          $display("%0t: unexpected result distance %h zero_norm %b saturated %b",
                   $time, distance_o, zero_norm_o, saturated_o);
      end else begin
        want = distance_q.pop_front();
        if (distance_o !== want.distance) begin
          errors++;
          if (errors < REPORT_LIMIT)
            $display("%0t: distance expected %h actual %h", $time, want.distance,
                     distance_o);
        end
        if (zero_norm_o !== want.zero_norm) begin
          errors++;
          if (errors < REPORT_LIMIT)
            $display("%0t: zero_norm expected %b actual %b", $time, want.zero_norm,
                     zero_norm_o);
        end
        if (saturated_o !== want.saturated) begin
          errors++;
          if (errors < REPORT_LIMIT)
            $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                     saturated_o);
        end
      end
    end
  end

  // count cycles in which nothing moves
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_mode();
    test_manhattan();
    test_cosine();
    test_unused_mode();
    test_full_scale();
    test_random();
    if (distance_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, distance_q.size());
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
